@@ rtl/core/touch_tap_gesture_classifier_defines.svh @@
// Assertion macros for the touch tap gesture classifier.
// The including module must provide the clk and rst signals.
// Define SYNTH to compile the checks away.
`ifndef TOUCH_TAP_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_TAP_GESTURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
// Checks a property at every clock edge outside reset.
`define TTG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("touch tap gesture classifier check failed");
// Checks that a condition in one cycle implies another in the next cycle.
`define TTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch tap gesture classifier sequence check failed");
`else
`define TTG_ASSERT(label, prop)
`define TTG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/ttg_pkg.sv @@
// Shared types and constants for the touch tap gesture classifier.
// No dependencies; imported by every module of the block.
package ttg_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int COUNT_W     = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  typedef logic [SAMPLE_W-1:0]    sample_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // Tick counter saturates at its all-ones value.
  localparam count_t COUNT_MAX = '1;

  // Configuration register indexes.
  localparam cfg_index_t REG_CONTACT_THRESHOLD = 3'd0;
  localparam cfg_index_t REG_REST_THRESHOLD    = 3'd1;
  localparam cfg_index_t REG_DOUBLE_TAP_ENABLE = 3'd2;
  localparam cfg_index_t REG_PRESS_LIMIT       = 3'd3;
  localparam cfg_index_t REG_HOLD_MINIMUM      = 3'd4;
  localparam cfg_index_t REG_DOUBLE_WINDOW     = 3'd5;

  // Register values after reset.
  localparam sample_t RST_CONTACT_THRESHOLD = 8'd0;
  localparam sample_t RST_REST_THRESHOLD    = 8'd255;
  localparam logic    RST_DOUBLE_TAP_ENABLE = 1'b1;
  localparam count_t  RST_PRESS_LIMIT       = 6'd18;
  localparam count_t  RST_HOLD_MINIMUM      = 6'd14;
  localparam count_t  RST_DOUBLE_WINDOW     = 6'd6;

  // Event codes reported once per sample.
  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_TAP    = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_HOLD   = 2'd3
  } gesture_t;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    sample_t contact_threshold;
    sample_t rest_threshold;
    logic    double_tap_enable;
    count_t  press_limit;
    count_t  hold_minimum;
    count_t  double_window;
  } cfg_t;

endpackage

@@ rtl/core/ttg_cfg_regs.sv @@
// Configuration register file of the touch tap gesture classifier.
// Depends on ttg_pkg for register indexes, reset values and cfg_t.
module ttg_cfg_regs
  import ttg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  cfg_index_t wr_index,
  input  cfg_data_t  wr_data,
  output cfg_t       cfg
);

  // Decode one register write per word; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contact_threshold <= RST_CONTACT_THRESHOLD;
      cfg.rest_threshold    <= RST_REST_THRESHOLD;
      cfg.double_tap_enable <= RST_DOUBLE_TAP_ENABLE;
      cfg.press_limit       <= RST_PRESS_LIMIT;
      cfg.hold_minimum      <= RST_HOLD_MINIMUM;
      cfg.double_window     <= RST_DOUBLE_WINDOW;
    end else if (wr_en) begin
      case (wr_index)
        REG_CONTACT_THRESHOLD: cfg.contact_threshold <= wr_data[SAMPLE_W-1:0];
        REG_REST_THRESHOLD:    cfg.rest_threshold    <= wr_data[SAMPLE_W-1:0];
        REG_DOUBLE_TAP_ENABLE: cfg.double_tap_enable <= wr_data[0];
        REG_PRESS_LIMIT:       cfg.press_limit       <= wr_data[COUNT_W-1:0];
        REG_HOLD_MINIMUM:      cfg.hold_minimum      <= wr_data[COUNT_W-1:0];
        REG_DOUBLE_WINDOW:     cfg.double_window     <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/ttg_classifier.sv @@
// Gesture state machine: press and wait phases with a saturating tick counter.
// Depends on ttg_pkg; produces one event per processed sample.
module ttg_classifier
  import ttg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  sample_t  sample,
  input  cfg_t     cfg,
  output gesture_t gesture
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRESS = 2'd1,
    PH_WAIT  = 2'd2
  } phase_t;

  phase_t  phase, phase_next;
  count_t  tick_count, tick_count_next;
  sample_t previous_sample;
  count_t  bumped;

  // Saturating increment of the tick counter.
  assign bumped = (tick_count == COUNT_MAX) ? tick_count : tick_count + count_t'(1);

  // Next phase, counter and event for the sample being processed.
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    gesture         = GEST_NONE;
    case (phase)
      PH_PRESS: begin
        tick_count_next = bumped;
        if (!(sample < cfg.contact_threshold && bumped <= cfg.press_limit)) begin
          tick_count_next = '0;
          if (bumped > cfg.hold_minimum) begin
            gesture    = GEST_HOLD;
            phase_next = PH_IDLE;
          end else if (cfg.double_tap_enable) begin
            phase_next = PH_WAIT;
          end else begin
            gesture    = GEST_TAP;
            phase_next = PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        tick_count_next = bumped;
        if (!(sample > cfg.rest_threshold && bumped <= cfg.double_window)) begin
          tick_count_next = '0;
          gesture    = (bumped > cfg.double_window) ? GEST_TAP : GEST_DOUBLE;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (previous_sample > cfg.rest_threshold && sample < cfg.contact_threshold) begin
          phase_next      = PH_PRESS;
          tick_count_next = '0;
        end
      end
    endcase
  end

  // State advances only when a sample moves on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_count      <= '0;
      previous_sample <= '0;
    end else if (step) begin
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      previous_sample <= sample;
    end
  end

endmodule

@@ rtl/core/touch_tap_gesture_classifier.sv @@
// Top level of the touch tap gesture classifier.
// Depends on ttg_pkg, ttg_cfg_regs, ttg_classifier and the assertion macro header.
//
// Usage:
//   Sample channel: sample_valid, sample_stall, touch_sample. One word per poll tick;
//   a word is taken at a rising edge with sample_valid high and sample_stall low.
//   Event channel: event_valid, event_stall, gesture_event. Every sample yields
//   exactly one event word (none, tap, double tap or hold), in sample order.
//   Configuration: cfg_valid, cfg_ready, cfg_index, cfg_data. cfg_ready is always
//   high; writes take effect in the next cycle and must be issued while the block is idle.
//   Path: a taken sample waits in the input register until the classifier step
//   moves it into the event register, which then offers its event word.
//   Throughput: one sample per cycle while no event word is stalled, set by the single
//   classifier step between the input register and the event register.
//   Stall: while event_stall holds a waiting word, one more sample fits in the
//   input register; after that sample_stall rises until the event word is taken.
//   Reset (rst, synchronous): both registers empty, gesture state idle, previous
//   sample zero, configuration at its default values.
`include "touch_tap_gesture_classifier_defines.svh"

module touch_tap_gesture_classifier
  import ttg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  sample_t    touch_sample,
  output logic       event_valid,
  input  logic       event_stall,
  output logic [1:0] gesture_event,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data
);

  cfg_t     cfg;
  logic     s1_valid;
  sample_t  s1_sample;
  logic     out_free;
  logic     step;
  gesture_t gesture;

  // Configuration register file.
  assign cfg_ready = 1'b1;

  ttg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Flow control between the input register and the event register.
  assign out_free     = !event_valid || !event_stall;
  assign step         = s1_valid && out_free;
  assign sample_stall = s1_valid && !out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
    if (!sample_stall && sample_valid) begin
      s1_sample <= touch_sample;
    end
  end

  // Gesture classifier.
  ttg_classifier u_classifier (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .sample  (s1_sample),
    .cfg     (cfg),
    .gesture (gesture)
  );

  // Event register.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_free) begin
      event_valid <= s1_valid;
    end
    if (step) begin
      gesture_event <= gesture;
    end
  end

  // Checks on the internal pipeline and the register file.
  `TTG_ASSERT(a_stall_needs_held_word, !sample_stall || s1_valid)
  `TTG_ASSERT_NEXT(a_step_fills_event, step, event_valid)
  `TTG_ASSERT_NEXT(a_held_word_stays, s1_valid && !step, s1_valid && $stable(s1_sample))
  `TTG_ASSERT_NEXT(a_contact_write, cfg_valid && cfg_ready && cfg_index == REG_CONTACT_THRESHOLD,
                   cfg.contact_threshold == $past(cfg_data))

endmodule
